### hw/rtl/escaped_frame_receiver_assert.svh
// assertion macros for the escaped frame receiver
// used by efr_ctrl and efr_datapath; expects clk and rst_n in scope
`ifndef ESCAPED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EFR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efr assertion failed");

// next-cycle implication, disabled during reset
`define EFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efr assertion failed");

`endif

### hw/rtl/efr_pkg.sv
// shared types and constants for the escaped frame receiver
// no dependencies; imported by efr_ctrl, efr_datapath and the top level
`timescale 1ns / 1ps

package efr_pkg;

    // frame buffer sizing
    localparam int BUFFER_DEPTH = 32;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 5;

    // line control bytes
    localparam logic [BYTE_W-1:0] BYTE_START   = 8'd254;
    localparam logic [BYTE_W-1:0] BYTE_END     = 8'd255;
    localparam logic [BYTE_W-1:0] BYTE_ESCAPE  = 8'd250;
    localparam logic [BYTE_W-1:0] ADDR_RESET   = 8'h02;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAME,
        ST_EMIT
    } efr_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear;      // drop stored bytes and pending escape
        logic store;      // write the unescaped byte into the buffer
        logic set_esc;    // mark escape pending
        logic load_emit;  // latch length, start readout at entry 0
        logic advance;    // step readout to the next entry
    } efr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_end;
        logic is_escape;
        logic full;       // buffer holds BUFFER_DEPTH bytes
        logic frame_ok;   // two or more bytes and address matches
        logic last;       // readout points at final message byte
    } efr_status_t;

endpackage

### hw/rtl/efr_ctrl.sv
// controller state machine for the escaped frame receiver
// depends on efr_pkg and escaped_frame_receiver_assert.svh
`timescale 1ns / 1ps

module efr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    input  logic                msg_ready,
    input  efr_pkg::efr_status_t status,
    output efr_pkg::efr_cmd_t   cmd,
    output logic                rx_ready,
    output logic                msg_valid
);
    import efr_pkg::*;

    `include "escaped_frame_receiver_assert.svh"

    efr_state_t state_reg;
    efr_state_t state_next;
    logic       rx_fire;

    assign rx_fire = rx_valid && rx_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid && status.is_start)
                begin
                    state_next = ST_FRAME;
                end
            end
            ST_FRAME:
            begin
                if (rx_valid)
                begin
                    priority if (status.is_start || status.is_escape)
                    begin
                        state_next = ST_FRAME;
                    end
                    else if (status.is_end)
                    begin
                        state_next = status.frame_ok ? ST_EMIT : ST_IDLE;
                    end
                    else if (status.full)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FRAME;
                    end
                end
            end
            ST_EMIT:
            begin
                if (msg_ready && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        cmd       = '0;
        rx_ready  = 1'b0;
        msg_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rx_ready  = 1'b1;
                cmd.clear = rx_fire && status.is_start;
            end
            ST_FRAME:
            begin
                rx_ready = 1'b1;
                if (rx_fire)
                begin
                    priority if (status.is_start)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (status.is_end)
                    begin
                        cmd.load_emit = status.frame_ok;
                        cmd.clear     = !status.frame_ok;
                    end
                    else if (status.is_escape)
                    begin
                        cmd.set_esc = 1'b1;
                    end
                    else if (status.full)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                msg_valid = 1'b1;
                if (msg_ready)
                begin
                    cmd.clear   = status.last;
                    cmd.advance = !status.last;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // a good end of frame starts readout, the final transfer ends it
    `EFR_ASSERT_NEXT(a_end_to_emit,
        state_reg == ST_FRAME && rx_valid && status.is_end && status.frame_ok,
        state_reg == ST_EMIT)
    `EFR_ASSERT_NEXT(a_last_to_idle,
        state_reg == ST_EMIT && msg_ready && status.last,
        state_reg == ST_IDLE)

endmodule

### hw/rtl/efr_datapath.sv
// datapath for the escaped frame receiver: unescape, frame buffer, readout
// depends on efr_pkg and escaped_frame_receiver_assert.svh
`timescale 1ns / 1ps

module efr_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [7:0]            cfg_write_data,
    input  logic [7:0]            rx_byte,
    input  efr_pkg::efr_cmd_t     cmd,
    output efr_pkg::efr_status_t  status,
    output logic [7:0]            msg_byte,
    output logic [4:0]            msg_length,
    output logic                  msg_last
);
    import efr_pkg::*;

    `include "escaped_frame_receiver_assert.svh"

    logic [BYTE_W-1:0]  addr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               esc_reg;
    logic               esc_next;
    logic [BYTE_W-1:0]  first_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;
    logic [IDX_W-1:0]   last_idx_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [BYTE_W-1:0]  rd_data_reg;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  frame_store_reg [BUFFER_DEPTH];

    // unescape the incoming data byte
    assign data_byte = esc_reg ? BYTE_W'(rx_byte + BYTE_ESCAPE) : rx_byte;

    // status toward the controller
    assign status.is_start  = (rx_byte == BYTE_START);
    assign status.is_end    = (rx_byte == BYTE_END);
    assign status.is_escape = (rx_byte == BYTE_ESCAPE);
    assign status.full      = (count_reg == COUNT_W'(BUFFER_DEPTH));
    assign status.frame_ok  = (count_reg >= COUNT_W'(2)) && (first_reg == addr_reg);
    assign status.last      = (rd_idx_reg == last_idx_reg);

    // device address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ADDR_RESET;
        end
        else if (cfg_write_en)
        begin
            addr_reg <= cfg_write_data;
        end
    end

    // fill count and escape flag
    always_comb
    begin
        count_next = count_reg;
        esc_next   = esc_reg;
        priority if (cmd.clear)
        begin
            count_next = '0;
            esc_next   = 1'b0;
        end
        else if (cmd.store)
        begin
            count_next = count_reg + COUNT_W'(1);
            esc_next   = 1'b0;
        end
        else if (cmd.set_esc)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            esc_next = esc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            esc_reg    <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            esc_reg    <= esc_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // readout pointer
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        priority if (cmd.load_emit)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.advance)
        begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
        else
        begin
            rd_idx_next = rd_idx_reg;
        end
    end

    // first byte copy, message length and final index
    always_ff @(posedge clk)
    begin
        if (cmd.store && count_reg == '0)
        begin
            first_reg <= data_byte;
        end
        if (cmd.load_emit)
        begin
            length_reg   <= LEN_W'(count_reg - COUNT_W'(1));
            last_idx_reg <= IDX_W'(count_reg - COUNT_W'(2));
        end
    end

    // frame buffer; read data tracks the entry at the readout pointer
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            frame_store_reg[count_reg[IDX_W-1:0]] <= data_byte;
        end
        rd_data_reg <= frame_store_reg[rd_idx_next];
    end

    assign msg_byte   = rd_data_reg;
    assign msg_length = length_reg;
    assign msg_last   = status.last;

    // never write past the buffer, never step beyond the message
    `EFR_ASSERT_SAME(a_store_not_full, cmd.store, !status.full)
    `EFR_ASSERT_SAME(a_advance_not_last, cmd.advance, !status.last)

endmodule

### hw/rtl/escaped_frame_receiver.sv
// Byte-stuffed serial frame receiver, top level.
// Input channel rx_valid/rx_ready/rx_byte takes one raw line byte per
// transfer. 254 starts or restarts a frame, 255 ends it, 250 escapes the
// next data byte (250 is added to it). Bytes outside a frame are ignored.
// Output channel msg_valid/msg_ready carries msg_byte, msg_length and
// msg_last: the stored message minus its trailing checksum, address first,
// sent only when two or more bytes were stored and the first matches
// device_address (cfg_write_en/cfg_write_data, reset value 2).
// rx_ready is high outside readout. After an accepted end byte the first
// message byte is valid on the next cycle, then one byte per cycle while
// msg_ready is high; rx_ready is low for the whole readout. The frame
// buffer read is registered, addressed by the next readout pointer.
// A stall on msg_ready holds the current byte and the readout pointer.
// A frame overrunning 32 bytes is dropped. Reset returns to idle with an
// empty buffer and needs no clearing pass.
// Depends on efr_pkg, efr_ctrl and efr_datapath.
`timescale 1ns / 1ps

module escaped_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       msg_valid,
    input  logic       msg_ready,
    output logic [7:0] msg_byte,
    output logic [4:0] msg_length,
    output logic       msg_last
);
    import efr_pkg::*;

    efr_cmd_t    cmd;
    efr_status_t status;

    // controller
    efr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .msg_ready (msg_ready),
        .status    (status),
        .cmd       (cmd),
        .rx_ready  (rx_ready),
        .msg_valid (msg_valid)
    );

    // datapath
    efr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .status         (status),
        .msg_byte       (msg_byte),
        .msg_length     (msg_length),
        .msg_last       (msg_last)
    );

endmodule

### tb/sv/tb_escaped_frame_receiver.sv
// testbench for the escaped frame receiver: directed frame table, then random framed traffic
// predicts untyped messages from accepted line bytes; depends on efr_pkg and the top level
`timescale 1ns / 1ps

module tb_escaped_frame_receiver;

    import efr_pkg::*;

    localparam int IDLE_PCT        = 34;
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_ITEMS    = 130;
    localparam int NUM_ROWS        = 15;
    // marks a table row whose results come from the predictor
    localparam int BY_PREDICTOR    = -1;

    // one expected transfer on the message channel
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  length;
        logic              last;
    } msg_beat_t;

    // one directed frame: head bytes, a run of fill bytes, tail bytes
    typedef struct packed {
        logic              cfg_en;
        logic [BYTE_W-1:0] cfg_val;
        int                head_n;
        logic [63:0]       head;
        int                fill_n;
        logic [BYTE_W-1:0] fill_val;
        int                tail_n;
        logic [31:0]       tail;
        int                n_msg;
    } frame_row_t;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_write_en   = 1'b0;
    logic [BYTE_W-1:0] cfg_write_data = '0;
    logic              rx_valid       = 1'b0;
    logic              rx_ready;
    logic [BYTE_W-1:0] rx_byte        = '0;
    logic              msg_valid;
    logic              msg_ready      = 1'b0;
    logic [BYTE_W-1:0] msg_byte;
    logic [LEN_W-1:0]  msg_length;
    logic              msg_last;

    // receiver copy kept by the predictor
    logic              rcv_in_frame;
    int                rcv_count;
    logic              rcv_escape;
    logic [BYTE_W-1:0] rcv_store [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rcv_addr;

    logic [BYTE_W-1:0] line_queue [$];
    msg_beat_t         msg_expected [$];
    msg_beat_t         want;
    frame_row_t        dir_rows [NUM_ROWS];
    bit                rx_took   = 1'b0;
    bit                calm      = 1'b0;
    bit                typed_row = 1'b0;
    int                cycle_count  = 0;
    int                mismatches   = 0;
    int                random_sent  = 0;

    escaped_frame_receiver u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_byte        (rx_byte),
        .msg_valid      (msg_valid),
        .msg_ready      (msg_ready),
        .msg_byte       (msg_byte),
        .msg_length     (msg_length),
        .msg_last       (msg_last)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic bit is_ctrl(input logic [BYTE_W-1:0] v);
        return v == BYTE_START || v == BYTE_END || v == BYTE_ESCAPE;
    endfunction

    // advance the receiver copy by one accepted line byte
    task automatic decode_line_byte(input logic [BYTE_W-1:0] b, input bit record);
        logic [BYTE_W-1:0] v;
        int                len;
        msg_beat_t         beat;
        v = b;
        if (!rcv_in_frame)
        begin
            // idle bytes are ignored, only a start opens a frame
            if (v == BYTE_START)
            begin
                rcv_in_frame = 1'b1;
                rcv_count    = 0;
                rcv_escape   = 1'b0;
            end
        end
        else if (v == BYTE_START)
        begin
            // restart drops what was stored
            rcv_count  = 0;
            rcv_escape = 1'b0;
        end
        else if (v == BYTE_END)
        begin
            if (rcv_count >= 2 && rcv_count <= BUFFER_DEPTH && rcv_store[0] == rcv_addr)
            begin
                len = rcv_count - 1;
                for (int k = 0; k < len; k++)
                begin
                    beat.data   = rcv_store[k];
                    beat.length = len[LEN_W-1:0];
                    beat.last   = (k == len - 1);
                    if (record)
                        msg_expected.push_back(beat);
                end
            end
            rcv_in_frame = 1'b0;
            rcv_count    = 0;
            rcv_escape   = 1'b0;
        end
        else if (v == BYTE_ESCAPE)
        begin
            rcv_escape = 1'b1;
        end
        else
        begin
            if (rcv_escape)
            begin
                v          = v + BYTE_ESCAPE;
                rcv_escape = 1'b0;
            end
            if (rcv_count >= BUFFER_DEPTH)
            begin
                // overrun drops the frame
                rcv_in_frame = 1'b0;
                rcv_count    = 0;
                rcv_escape   = 1'b0;
            end
            else
            begin
                rcv_store[rcv_count] = v;
                rcv_count++;
            end
        end
    endtask

    // line byte driver, new transfer only once the previous one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!rx_valid || rx_took)
            begin
                if (line_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    rx_byte  <= line_queue.pop_front();
                    rx_valid <= 1'b1;
                end
                else
                begin
                    rx_valid <= 1'b0;
                end
            end
            msg_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // sample both channels, predict and check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
            begin
                rx_took = rx_valid && rx_ready;
                if (rx_took)
                    decode_line_byte(rx_byte, !typed_row);
                if (msg_valid && msg_ready)
                begin
                    if (msg_expected.size() == 0)
                    begin
                        flag_mismatch($sformatf("unexpected message byte %02h", msg_byte));
                    end
                    else
                    begin
                        want = msg_expected.pop_front();
                        if (msg_byte !== want.data)
                            flag_mismatch($sformatf("msg_byte got %02h want %02h",
                                                    msg_byte, want.data));
                        if (msg_length !== want.length)
                            flag_mismatch($sformatf("msg_length got %0d want %0d",
                                                    msg_length, want.length));
                        if (msg_last !== want.last)
                            flag_mismatch($sformatf("msg_last got %0b want %0b",
                                                    msg_last, want.last));
                    end
                end
            end
        end
    end

    // wait until every line byte is taken and every message byte is out
    task automatic settle_receiver();
        do
            @(posedge clk);
        while (line_queue.size() != 0 || (rx_valid && !rx_ready));
        @(negedge clk);
        while (msg_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write, called at a falling edge with the receiver idle
    task automatic write_address(input logic [BYTE_W-1:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        rcv_addr = v;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // queue one data byte, escaped when it has to be or now and then anyway
    task automatic queue_data_byte(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] coded;
        coded = v - BYTE_ESCAPE;
        if (is_ctrl(v) || (!is_ctrl(coded) && $urandom_range(0, 15) == 0))
        begin
            line_queue.push_back(BYTE_ESCAPE);
            random_sent++;
            // a second escape stays a single pending escape
            if ($urandom_range(0, 7) == 0)
            begin
                line_queue.push_back(BYTE_ESCAPE);
                random_sent++;
            end
            line_queue.push_back(coded);
        end
        else
        begin
            line_queue.push_back(v);
        end
        random_sent++;
    endtask

    // one random frame, mostly well formed, sometimes noise or broken
    task automatic queue_random_frame();
        int                kind;
        int                n;
        int                ending;
        logic [BYTE_W-1:0] v;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // noise between frames
            repeat ($urandom_range(1, 4))
            begin
                v = 8'($urandom_range(0, 255));
                if (v == BYTE_START)
                    v = 8'h00;
                line_queue.push_back(v);
                random_sent++;
            end
        end
        else
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(29, 33) : $urandom_range(0, 6);
            line_queue.push_back(BYTE_START);
            random_sent++;
            if ($urandom_range(0, 99) < 85)
                queue_data_byte(rcv_addr);
            else
                queue_data_byte(8'($urandom_range(0, 255)));
            for (int k = 0; k < n; k++)
                queue_data_byte(8'($urandom_range(0, 255)));
            ending = $urandom_range(0, 99);
            if (ending < 85)
            begin
                line_queue.push_back(BYTE_END);
                random_sent++;
            end
            else if (ending < 92)
            begin
                // escape then end
                line_queue.push_back(BYTE_ESCAPE);
                line_queue.push_back(BYTE_END);
                random_sent += 2;
            end
            // otherwise no end byte: the next start restarts the frame
        end
    endtask

    // directed frame table
    initial
    begin
        // idle noise, escape and end while idle are ignored
        dir_rows[0]  = '{1'b0, 8'h00, 4, 64'({8'h00, 8'hFF, 8'h55, BYTE_ESCAPE}),
                         0, 8'h00, 0, 32'h0, 0};
        // reset address, two bytes out, checksum dropped
        dir_rows[1]  = '{1'b0, 8'h00, 5, 64'({BYTE_START, ADDR_RESET, 8'h11, 8'h99, BYTE_END}),
                         0, 8'h00, 0, 32'h0, 2};
        // short frame
        dir_rows[2]  = '{1'b0, 8'h00, 3, 64'({BYTE_START, ADDR_RESET, BYTE_END}),
                         0, 8'h00, 0, 32'h0, 0};
        // empty frame
        dir_rows[3]  = '{1'b0, 8'h00, 2, 64'({BYTE_START, BYTE_END}),
                         0, 8'h00, 0, 32'h0, 0};
        // shortest message
        dir_rows[4]  = '{1'b0, 8'h00, 4, 64'({BYTE_START, ADDR_RESET, 8'hAA, BYTE_END}),
                         0, 8'h00, 0, 32'h0, 1};
        // wrong address
        dir_rows[5]  = '{1'b0, 8'h00, 5, 64'({BYTE_START, 8'h03, 8'h01, 8'h02, BYTE_END}),
                         0, 8'h00, 0, 32'h0, 0};
        // escaped start and end values as data
        dir_rows[6]  = '{1'b0, 8'h00, 8, {BYTE_START, ADDR_RESET, BYTE_ESCAPE, 8'h04,
                         BYTE_ESCAPE, 8'h05, 8'h07, BYTE_END}, 0, 8'h00, 0, 32'h0, BY_PREDICTOR};
        // repeated escape
        dir_rows[7]  = '{1'b0, 8'h00, 7, 64'({BYTE_START, ADDR_RESET, BYTE_ESCAPE, BYTE_ESCAPE,
                         8'h00, 8'h09, BYTE_END}), 0, 8'h00, 0, 32'h0, BY_PREDICTOR};
        // escape then end
        dir_rows[8]  = '{1'b0, 8'h00, 5,
                         64'({BYTE_START, ADDR_RESET, 8'h08, BYTE_ESCAPE, BYTE_END}),
                         0, 8'h00, 0, 32'h0, BY_PREDICTOR};
        // restart inside a frame
        dir_rows[9]  = '{1'b0, 8'h00, 8, {BYTE_START, ADDR_RESET, 8'h01, BYTE_START,
                         ADDR_RESET, 8'h03, 8'h04, BYTE_END}, 0, 8'h00, 0, 32'h0, BY_PREDICTOR};
        // lowest address
        dir_rows[10] = '{1'b1, 8'h00, 5, 64'({BYTE_START, 8'h00, 8'h00, 8'h00, BYTE_END}),
                         0, 8'h00, 0, 32'h0, 2};
        // highest address, reachable only through an escape
        dir_rows[11] = '{1'b1, 8'hFF, 6, 64'({BYTE_START, BYTE_ESCAPE, 8'h05, 8'h12, 8'h34,
                         BYTE_END}), 0, 8'h00, 0, 32'h0, BY_PREDICTOR};
        // buffer exactly full, longest message
        dir_rows[12] = '{1'b1, ADDR_RESET, 2, 64'({BYTE_START, ADDR_RESET}),
                         30, 8'hC3, 2, 32'({8'h5A, BYTE_END}), 31};
        // overrun drops the frame, the end byte is then ignored
        dir_rows[13] = '{1'b0, 8'h00, 2, 64'({BYTE_START, ADDR_RESET}),
                         31, 8'h3C, 2, 32'({8'h77, BYTE_END}), 0};
        // recovery after overrun
        dir_rows[14] = '{1'b0, 8'h00, 6, 64'({BYTE_START, ADDR_RESET, 8'h40, 8'h41, 8'h42,
                         BYTE_END}), 0, 8'h00, 0, 32'h0, 3};
    end

    // reset, directed table, random phases, final verdict
    initial
    begin
        logic [BYTE_W-1:0] row_bytes [$];
        logic [BYTE_W-1:0] addr;
        frame_row_t        row;
        msg_beat_t         beat;
        int                phase;

        rcv_in_frame = 1'b0;
        rcv_count    = 0;
        rcv_escape   = 1'b0;
        rcv_addr     = ADDR_RESET;
        foreach (rcv_store[i])
            rcv_store[i] = '0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows, each run to completion
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = dir_rows[r];
            row_bytes.delete();
            for (int i = 0; i < row.head_n; i++)
                row_bytes.push_back(row.head[8*(row.head_n-1-i) +: 8]);
            repeat (row.fill_n) row_bytes.push_back(row.fill_val);
            for (int i = 0; i < row.tail_n; i++)
                row_bytes.push_back(row.tail[8*(row.tail_n-1-i) +: 8]);
            if (row.cfg_en)
                write_address(row.cfg_val);
            typed_row = (row.n_msg != BY_PREDICTOR);
            // typed rows: message is the bytes after the start, checksum left off
            for (int k = 0; k < row.n_msg; k++)
            begin
                beat.data   = row_bytes[k+1];
                beat.length = row.n_msg[LEN_W-1:0];
                beat.last   = (k == row.n_msg - 1);
                msg_expected.push_back(beat);
            end
            foreach (row_bytes[i])
                line_queue.push_back(row_bytes[i]);
            settle_receiver();
            typed_row = 1'b0;
        end

        // random phases, a new address for each
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle_receiver();
            // close a frame left open so the address changes with the receiver idle
            if (rcv_in_frame)
            begin
                line_queue.push_back(BYTE_END);
                random_sent++;
                settle_receiver();
            end
            calm = (phase == 2);
            case (phase % 5)
                0:       addr = 8'h00;
                1:       addr = 8'hFF;
                2:       addr = ADDR_RESET;
                default: addr = 8'($urandom_range(0, 255));
            endcase
            write_address(addr);
            repeat (6) queue_random_frame();
            phase++;
        end

        settle_receiver();
        calm = 1'b0;
        repeat (END_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/efr_pkg.sv
hw/rtl/efr_ctrl.sv
hw/rtl/efr_datapath.sv
hw/rtl/escaped_frame_receiver.sv
tb/sv/tb_escaped_frame_receiver.sv
